// ----- sv/lru_block_buffer_cache_tags_top_assert.svh -----
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_tags_top_assert
// assertion macros shared by the cache tag engine
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_TAGS_TOP_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_TAGS_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define LBBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbbc assertion failed");

// next-cycle implication, masked during reset
`define LBBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbbc assertion failed");

`endif

// ----- sv/lbbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbbc_pkg
// shared widths, codes and structs of the block cache tag engine
// ----------------------------------------------------------------------------
package lbbc_pkg;

  localparam int SlotIdxW = 6;   // enough for up to 64 slots
  localparam int SectorW  = 32;
  localparam int OutSlotW = 4;
  localparam int MaxRes   = 16;  // flushes per sync request
  localparam int ResCntW  = 4;
  localparam int CfgIdxW  = 8;

  localparam logic [1:0] ActGet = 2'd0;
  localparam logic [1:0] ActPut = 2'd1;
  localparam logic [1:0] ActSync = 2'd2;
  localparam logic [1:0] ActInval = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgWtImm = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWtEvery = 8'd1;

  typedef enum logic [2:0] {
    OP_NONE, OP_HIT_FRONT, OP_ALLOC, OP_PUT, OP_INV_STEP
  } cell_op_e;

  typedef enum logic [2:0] {
    SEL_NONE, SEL_SECTOR, SEL_SLOT, SEL_LRU_RANK, SEL_DIRTY_RANK, SEL_FREE_HEAD
  } probe_sel_e;

  typedef struct packed {
    cell_op_e              op;
    probe_sel_e            sel;
    logic [SlotIdxW-1:0]   key_slot;
    logic [SectorW-1:0]    key_sector;
    logic [SlotIdxW-1:0]   q_slot;
    logic [SlotIdxW-1:0]   q_rank;
    logic [SlotIdxW-1:0]   rank;
    logic [SlotIdxW-1:0]   lru_tail;
    logic [SlotIdxW-1:0]   drank;
    logic [SlotIdxW-1:0]   new_drank;
    logic                  from_free;
    logic                  oneshot;
    logic                  set_dirty;
    logic                  drop_dirty;
    logic                  key_valid;
  } cell_cmd_t;

  typedef struct packed {
    logic                  found;
    logic                  valid;
    logic                  dirty;
    logic [SlotIdxW-1:0]   slot;
    logic [SectorW-1:0]    sector;
    logic [SlotIdxW-1:0]   lru_rank;
    logic [SlotIdxW-1:0]   drank;
  } probe_t;

  typedef struct packed {
    logic [OutSlotW-1:0]   slot;
    logic                  hit;
    logic                  fill_read;
    logic                  write_out;
    logic [OutSlotW-1:0]   write_slot;
    logic [SectorW-1:0]    write_sector;
    logic                  status;
    logic                  last;
  } out_item_t;

endpackage

// ----- sv/lbbc_if.sv -----
// ----------------------------------------------------------------------------
// lbbc_if
// request, result and register-write channels of the block cache tag engine
// ----------------------------------------------------------------------------
interface lbbc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [lbbc_pkg::SectorW-1:0] block_number;
  logic [3:0] slot_index;
  logic [1:0] put_mode;
  modport source (output valid, action, block_number, slot_index, put_mode, input ready);
  modport sink (input valid, action, block_number, slot_index, put_mode, output ready);
endinterface

interface lbbc_out_if;
  logic valid;
  logic ready;
  logic [lbbc_pkg::OutSlotW-1:0] slot;
  logic hit;
  logic fill_read;
  logic write_out;
  logic [lbbc_pkg::OutSlotW-1:0] write_slot;
  logic [lbbc_pkg::SectorW-1:0] write_sector;
  logic status;
  logic last;
  modport source (output valid, slot, hit, fill_read, write_out, write_slot, write_sector,
                  status, last, input ready);
  modport sink (input valid, slot, hit, fill_read, write_out, write_slot, write_sector,
                status, last, output ready);
endinterface

interface lbbc_cfg_if;
  logic valid;
  logic ready;
  logic [lbbc_pkg::CfgIdxW-1:0] index;
  logic data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/lru_block_buffer_cache_tags_top.sv -----
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_tags_top
// tag and replacement engine of an lru write-back block cache
// ----------------------------------------------------------------------------
// A get probes the row for its sector and, on a miss, once more for a free
// slot or the lru victim before it allocates; a put probes for its slot; a
// sync probes the dirty queue head before each flush (at most 16 per request)
// and goes straight to an empty result when nothing is dirty; an invalidate
// steps through the slots one per cycle. Each probe of the row of slot cells
// finds a sector, a slot or a list rank, and each hit, put, fill or flush
// then broadcasts one list update; a stalled result channel adds its wait.
// One request is in work at a time; the result register lets the next
// request come in while the last result still waits for its transfer.
// ----------------------------------------------------------------------------
`include "lru_block_buffer_cache_tags_top_assert.svh"

module lru_block_buffer_cache_tags_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbbc_in_if.sink    in_i,
  lbbc_out_if.source out_o,
  lbbc_cfg_if.sink   cfg_i
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_ALLOC, S_SYNC_Q, S_SYNC_EMIT,
    S_INV_Q, S_INV, S_EMIT_ZERO
  } state_e;

  state_e state_q, state_d;
  logic [1:0] act_q, act_d, mode_q, mode_d;
  logic [lbbc_pkg::SectorW-1:0] block_q, block_d;
  logic [3:0] sidx_q, sidx_d;
  lbbc_pkg::probe_t res_q, res_d;
  logic from_free_q, from_free_d;
  logic [CW-1:0] lru_cnt_q, lru_cnt_d, free_cnt_q, free_cnt_d, dirty_cnt_q, dirty_cnt_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [lbbc_pkg::ResCntW-1:0] k_q, k_d;
  logic wt_imm_q, wt_imm_d, wt_every_q, wt_every_d;
  logic out_valid_q, out_valid_d;
  lbbc_pkg::out_item_t out_q, out_d;

  lbbc_pkg::cell_cmd_t cmd;
  lbbc_pkg::probe_t    chain [NUM_SLOTS+1];
  lbbc_pkg::probe_t    probe;
  lbbc_pkg::out_item_t item;
  logic emit, out_free, wo;
  logic [CW:0] slot_total;

  // row of slot cells; the probe result ripples from cell 0 to the last one
  assign chain[0] = '0;
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    lbbc_cell #(.SW(SW), .ID(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .probe_i (chain[g]),
      .probe_o (chain[g+1])
    );
  end
  assign probe = chain[NUM_SLOTS];

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    mode_d      = mode_q;
    block_d     = block_q;
    sidx_d      = sidx_q;
    res_d       = res_q;
    from_free_d = from_free_q;
    lru_cnt_d   = lru_cnt_q;
    free_cnt_d  = free_cnt_q;
    dirty_cnt_d = dirty_cnt_q;
    idx_d       = idx_q;
    k_d         = k_q;
    wt_imm_d    = wt_imm_q;
    wt_every_d  = wt_every_q;
    cmd         = '0;
    item        = '0;
    emit        = 1'b0;
    wo          = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d   = in_i.action;
          block_d = in_i.block_number;
          sidx_d  = in_i.slot_index;
          mode_d  = in_i.put_mode;
          k_d     = '0;
          case (in_i.action)
            lbbc_pkg::ActSync:  state_d = (dirty_cnt_q == '0) ? S_EMIT_ZERO : S_SYNC_Q;
            lbbc_pkg::ActInval: state_d = S_INV_Q;
            default:            state_d = S_LOOK;
          endcase
        end
      end
      S_LOOK: begin
        // find the sector for a get, or the named slot for a put
        cmd.sel        = (act_q == lbbc_pkg::ActGet) ? lbbc_pkg::SEL_SECTOR
                                                     : lbbc_pkg::SEL_SLOT;
        cmd.key_sector = block_q;
        cmd.q_slot     = lbbc_pkg::SlotIdxW'(sidx_q);
        res_d          = probe;
        state_d        = S_DECIDE;
      end
      S_DECIDE: begin
        if (act_q == lbbc_pkg::ActGet) begin
          if (res_q.found) begin
            if (out_free) begin
              cmd.op       = lbbc_pkg::OP_HIT_FRONT;
              cmd.key_slot = res_q.slot;
              cmd.rank     = res_q.lru_rank;
              emit         = 1'b1;
              item.slot    = res_q.slot[lbbc_pkg::OutSlotW-1:0];
              item.hit     = 1'b1;
              item.last    = 1'b1;
              state_d      = S_IDLE;
            end
          end else if (free_cnt_q != '0) begin
            cmd.sel     = lbbc_pkg::SEL_FREE_HEAD;
            res_d       = probe;
            from_free_d = 1'b1;
            state_d     = S_ALLOC;
          end else begin
            // no free slot: the victim is the lru tail
            cmd.sel     = lbbc_pkg::SEL_LRU_RANK;
            cmd.q_rank  = lbbc_pkg::SlotIdxW'(lru_cnt_q - CW'(1));
            res_d       = probe;
            from_free_d = 1'b0;
            state_d     = S_ALLOC;
          end
        end else if (out_free) begin
          state_d = S_IDLE;
          emit    = 1'b1;
          item.last = 1'b1;
          if (!res_q.valid) begin
            // slot not in use or beyond the row
            item.slot   = sidx_q;
            item.status = 1'b1;
          end else begin
            cmd.op         = lbbc_pkg::OP_PUT;
            cmd.key_slot   = res_q.slot;
            cmd.oneshot    = mode_q[1];
            cmd.rank       = res_q.lru_rank;
            cmd.lru_tail   = lbbc_pkg::SlotIdxW'(lru_cnt_q - CW'(1));
            cmd.drop_dirty = mode_q[0] && res_q.dirty;
            cmd.drank      = res_q.drank;
            cmd.set_dirty  = !mode_q[0] && !res_q.dirty;
            cmd.new_drank  = lbbc_pkg::SlotIdxW'(dirty_cnt_q);
            if (cmd.drop_dirty) begin
              dirty_cnt_d = dirty_cnt_q - CW'(1);
            end else if (cmd.set_dirty) begin
              dirty_cnt_d = dirty_cnt_q + CW'(1);
            end
            wo                = mode_q[0] ? wt_imm_q : wt_every_q;
            item.slot         = res_q.slot[lbbc_pkg::OutSlotW-1:0];
            item.write_out    = wo;
            item.write_slot   = wo ? res_q.slot[lbbc_pkg::OutSlotW-1:0] : '0;
            item.write_sector = wo ? res_q.sector : '0;
          end
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          wo             = !from_free_q && res_q.dirty;
          cmd.op         = lbbc_pkg::OP_ALLOC;
          cmd.key_slot   = res_q.slot;
          cmd.key_sector = block_q;
          cmd.from_free  = from_free_q;
          cmd.drop_dirty = wo;
          cmd.drank      = res_q.drank;
          if (from_free_q) begin
            free_cnt_d = free_cnt_q - CW'(1);
            lru_cnt_d  = lru_cnt_q + CW'(1);
          end
          if (wo) begin
            dirty_cnt_d = dirty_cnt_q - CW'(1);
          end
          emit              = 1'b1;
          item.slot         = res_q.slot[lbbc_pkg::OutSlotW-1:0];
          item.fill_read    = 1'b1;
          item.write_out    = wo;
          item.write_slot   = wo ? res_q.slot[lbbc_pkg::OutSlotW-1:0] : '0;
          item.write_sector = wo ? res_q.sector : '0;
          item.last         = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_SYNC_Q: begin
        cmd.sel    = lbbc_pkg::SEL_DIRTY_RANK;
        cmd.q_rank = '0;
        res_d      = probe;
        state_d    = S_SYNC_EMIT;
      end
      S_SYNC_EMIT: begin
        if (out_free) begin
          cmd.drop_dirty    = 1'b1;
          cmd.key_slot      = res_q.slot;
          cmd.drank         = '0;
          dirty_cnt_d       = dirty_cnt_q - CW'(1);
          k_d               = k_q + lbbc_pkg::ResCntW'(1);
          emit              = 1'b1;
          item.slot         = res_q.slot[lbbc_pkg::OutSlotW-1:0];
          item.write_out    = 1'b1;
          item.write_slot   = res_q.slot[lbbc_pkg::OutSlotW-1:0];
          item.write_sector = res_q.sector;
          item.last         = (dirty_cnt_q == CW'(1)) ||
                              (k_q == lbbc_pkg::ResCntW'(lbbc_pkg::MaxRes - 1));
          state_d           = item.last ? S_IDLE : S_SYNC_Q;
        end
      end
      S_INV_Q: begin
        cmd.sel    = lbbc_pkg::SEL_SLOT;
        cmd.q_slot = '0;
        res_d      = probe;
        idx_d      = '0;
        state_d    = S_INV;
      end
      S_INV: begin
        // free slot idx while probing the next one
        cmd.op        = lbbc_pkg::OP_INV_STEP;
        cmd.key_slot  = lbbc_pkg::SlotIdxW'(idx_q);
        cmd.key_valid = res_q.valid;
        cmd.sel       = lbbc_pkg::SEL_SLOT;
        cmd.q_slot    = lbbc_pkg::SlotIdxW'(idx_q) + lbbc_pkg::SlotIdxW'(1);
        res_d         = probe;
        idx_d         = idx_q + SW'(1);
        if (idx_q == SW'(NUM_SLOTS - 1)) begin
          lru_cnt_d   = '0;
          dirty_cnt_d = '0;
          free_cnt_d  = CW'(NUM_SLOTS);
          state_d     = S_EMIT_ZERO;
        end
      end
      S_EMIT_ZERO: begin
        if (out_free) begin
          emit      = 1'b1;
          item.last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_i.valid) begin
      if (cfg_i.index == lbbc_pkg::CfgWtImm) begin
        wt_imm_d = cfg_i.data;
      end else if (cfg_i.index == lbbc_pkg::CfgWtEvery) begin
        wt_every_d = cfg_i.data;
      end
    end
  end

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = item;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lru_cnt_q   <= '0;
      free_cnt_q  <= CW'(NUM_SLOTS);
      dirty_cnt_q <= '0;
      wt_imm_q    <= 1'b0;
      wt_every_q  <= 1'b0;
      out_valid_q <= 1'b0;
      from_free_q <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      lru_cnt_q   <= lru_cnt_d;
      free_cnt_q  <= free_cnt_d;
      dirty_cnt_q <= dirty_cnt_d;
      wt_imm_q    <= wt_imm_d;
      wt_every_q  <= wt_every_d;
      out_valid_q <= out_valid_d;
      from_free_q <= from_free_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    mode_q  <= mode_d;
    block_q <= block_d;
    sidx_q  <= sidx_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.slot         = out_q.slot;
  assign out_o.hit          = out_q.hit;
  assign out_o.fill_read    = out_q.fill_read;
  assign out_o.write_out    = out_q.write_out;
  assign out_o.write_slot   = out_q.write_slot;
  assign out_o.write_sector = out_q.write_sector;
  assign out_o.status       = out_q.status;
  assign out_o.last         = out_q.last;

  assign slot_total = {1'b0, lru_cnt_q} + {1'b0, free_cnt_q};

  // every slot is either on the lru list or on the free list
  `LBBC_ASSERT_IMPL(a_counts_cover_slots, clk_i, rst_ni, 1'b1, slot_total == (CW+1)'(NUM_SLOTS))
  // dirty slots are a subset of the slots in use
  `LBBC_ASSERT_IMPL(a_dirty_within_lru, clk_i, rst_ni, 1'b1, dirty_cnt_q <= lru_cnt_q)
  // a flush step always has a dirty slot to write
  `LBBC_ASSERT_IMPL(a_sync_has_dirty, clk_i, rst_ni, state_q == S_SYNC_EMIT, dirty_cnt_q != '0)
  // a new request is held off while one is in work
  `LBBC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)

endmodule

// ----- sv/lbbc_cell.sv -----
// ----------------------------------------------------------------------------
// lbbc_cell
// one slot: sector tag, flags and its ranks in the lru, dirty and free lists
// ----------------------------------------------------------------------------
module lbbc_cell #(
  parameter int SW = 4,
  parameter int ID = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbbc_pkg::cell_cmd_t cmd_i,
  input  lbbc_pkg::probe_t    probe_i,
  output lbbc_pkg::probe_t    probe_o
);

  logic valid_q, valid_d, dirty_q, dirty_d;
  logic [lbbc_pkg::SectorW-1:0] sector_q, sector_d;
  logic [SW-1:0] lru_q, lru_d, drank_q, drank_d, free_q, free_d;
  logic is_key, sel;
  lbbc_pkg::probe_t mine;

  assign is_key = (cmd_i.key_slot == lbbc_pkg::SlotIdxW'(ID));

  always_comb begin
    valid_d  = valid_q;
    dirty_d  = dirty_q;
    sector_d = sector_q;
    lru_d    = lru_q;
    drank_d  = drank_q;
    free_d   = free_q;
    case (cmd_i.op)
      lbbc_pkg::OP_HIT_FRONT: begin
        if (valid_q) begin
          if (is_key) begin
            lru_d = '0;
          end else if (lru_q < cmd_i.rank[SW-1:0]) begin
            lru_d = lru_q + SW'(1);
          end
        end
      end
      lbbc_pkg::OP_ALLOC: begin
        if (is_key) begin
          valid_d  = 1'b1;
          dirty_d  = 1'b0;
          sector_d = cmd_i.key_sector;
          lru_d    = '0;
        end else if (valid_q) begin
          lru_d = lru_q + SW'(1);
        end else if (cmd_i.from_free) begin
          free_d = free_q - SW'(1);
        end
      end
      lbbc_pkg::OP_PUT: begin
        if (cmd_i.oneshot && valid_q) begin
          if (is_key) begin
            lru_d = cmd_i.lru_tail[SW-1:0];
          end else if (lru_q > cmd_i.rank[SW-1:0]) begin
            lru_d = lru_q - SW'(1);
          end
        end
        if (cmd_i.set_dirty && is_key) begin
          dirty_d = 1'b1;
          drank_d = cmd_i.new_drank[SW-1:0];
        end
      end
      lbbc_pkg::OP_INV_STEP: begin
        if (cmd_i.key_valid) begin
          if (is_key) begin
            valid_d = 1'b0;
            dirty_d = 1'b0;
            free_d  = '0;
          end else if (!valid_q) begin
            free_d = free_q + SW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    // leaving the dirty queue closes the gap behind the slot
    if (cmd_i.drop_dirty) begin
      if (is_key) begin
        dirty_d = 1'b0;
      end else if (dirty_q && (drank_q > cmd_i.drank[SW-1:0])) begin
        drank_d = drank_q - SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      free_q  <= SW'(ID);
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    lru_q    <= lru_d;
    drank_q  <= drank_d;
  end

  always_comb begin
    case (cmd_i.sel)
      lbbc_pkg::SEL_SECTOR:     sel = valid_q && (sector_q == cmd_i.key_sector);
      lbbc_pkg::SEL_SLOT:       sel = (cmd_i.q_slot == lbbc_pkg::SlotIdxW'(ID));
      lbbc_pkg::SEL_LRU_RANK:   sel = valid_q && (lru_q == cmd_i.q_rank[SW-1:0]);
      lbbc_pkg::SEL_DIRTY_RANK: sel = dirty_q && (drank_q == cmd_i.q_rank[SW-1:0]);
      lbbc_pkg::SEL_FREE_HEAD:  sel = !valid_q && (free_q == '0);
      default:                  sel = 1'b0;
    endcase
  end

  always_comb begin
    mine          = '0;
    mine.found    = 1'b1;
    mine.valid    = valid_q;
    mine.dirty    = dirty_q;
    mine.slot     = lbbc_pkg::SlotIdxW'(ID);
    mine.sector   = sector_q;
    mine.lru_rank = lbbc_pkg::SlotIdxW'(lru_q);
    mine.drank    = lbbc_pkg::SlotIdxW'(drank_q);
  end

  // the selected cell merges its record into the chain
  assign probe_o = lbbc_pkg::probe_t'(probe_i | (sel ? mine : '0));

endmodule

// ----- tb/tb_lru_block_buffer_cache_tags_top.sv -----
// ----------------------------------------------------------------------------
// tb_lru_block_buffer_cache_tags_top
// self-checking bench for the block cache tag engine: a directed table, a dirty
// fill and evict run, then random traffic over a small sector pool, checked against
// a local model and, for some directed rows, typed expectations
module tb_lru_block_buffer_cache_tags_top;

  localparam int NSLOT = 16;

  // typed expectations for the rows that read off at a glance
  localparam lbbc_pkg::out_item_t ExpLast = '{last: 1'b1, default: '0};
  localparam lbbc_pkg::out_item_t ExpBadSlot15 =
    '{slot: 4'd15, status: 1'b1, last: 1'b1, default: '0};
  localparam lbbc_pkg::out_item_t ExpBadSlot0 = '{status: 1'b1, last: 1'b1, default: '0};
  localparam lbbc_pkg::out_item_t ExpFill0 = '{fill_read: 1'b1, last: 1'b1, default: '0};
  localparam lbbc_pkg::out_item_t ExpFill1 =
    '{slot: 4'd1, fill_read: 1'b1, last: 1'b1, default: '0};
  localparam lbbc_pkg::out_item_t ExpHit0 = '{hit: 1'b1, last: 1'b1, default: '0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  lbbc_in_if  req_if ();
  lbbc_out_if res_if ();
  lbbc_cfg_if cfg_if ();

  lru_block_buffer_cache_tags_top #(.NUM_SLOTS(NSLOT)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  // model of the slot row and its three lists
  logic [31:0] m_sector [NSLOT];
  logic        m_valid [NSLOT];
  logic        m_dirty [NSLOT];
  logic [3:0]  lru_q [$];
  logic [3:0]  free_q [$];
  logic [3:0]  dirty_q [$];
  logic        wt_imm, wt_every;

  lbbc_pkg::out_item_t result_q [$];
  int          n_errors = 0;
  bit          quiet = 1'b0;   // no idling in the last part of the run

  task automatic report(input string what);
    n_errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void drop_from(ref logic [3:0] q [$], input logic [3:0] s);
    foreach (q[i]) if (q[i] == s) begin
      q.delete(i);
      return;
    end
  endfunction

  function automatic lbbc_pkg::out_item_t mk(input logic [3:0] slot, input logic hit,
                                             input logic fill, input logic wo,
                                             input logic [3:0] ws, input logic [31:0] wsec,
                                             input logic st, input logic lst);
    lbbc_pkg::out_item_t r;
    r.slot = slot; r.hit = hit; r.fill_read = fill; r.write_out = wo;
    r.write_slot = wo ? ws : 4'd0; r.write_sector = wo ? wsec : 32'd0;
    r.status = st; r.last = lst;
    return r;
  endfunction

  // predicted results of one request, pushed onto result_q
  task automatic predict_request(input logic [1:0] act, input logic [31:0] blk,
                                 input logic [3:0] sidx, input logic [1:0] mode);
    logic [3:0] s;
    logic wo;
    logic [31:0] wsec;
    int k;
    case (act)
      lbbc_pkg::ActGet: begin
        for (int i = 0; i < NSLOT; i++) if (m_valid[i] && m_sector[i] == blk) begin
          drop_from(lru_q, i[3:0]);
          lru_q.push_front(i[3:0]);
          result_q.push_back(mk(i[3:0], 1, 0, 0, 0, 0, 0, 1));
          return;
        end
        wo = 0; wsec = 0; s = 0;
        if (free_q.size() > 0) s = free_q.pop_front();
        else begin
          s = lru_q[$];
          if (m_dirty[s]) begin
            wo = 1; wsec = m_sector[s];
            drop_from(dirty_q, s);
          end
          drop_from(lru_q, s);
        end
        m_valid[s] = 1; m_dirty[s] = 0; m_sector[s] = blk;
        lru_q.push_front(s);
        result_q.push_back(mk(s, 0, 1, wo, s, wsec, 0, 1));
      end
      lbbc_pkg::ActPut: begin
        if (!m_valid[sidx]) begin
          result_q.push_back(mk(sidx, 0, 0, 0, 0, 0, 1, 1));
          return;
        end
        if (mode[1]) begin
          drop_from(lru_q, sidx);
          lru_q.push_back(sidx);
        end
        if (mode[0]) begin
          if (m_dirty[sidx]) begin
            m_dirty[sidx] = 0;
            drop_from(dirty_q, sidx);
          end
          wo = wt_imm;
        end else begin
          if (!m_dirty[sidx]) begin
            m_dirty[sidx] = 1;
            dirty_q.push_back(sidx);
          end
          wo = wt_every;
        end
        result_q.push_back(mk(sidx, 0, 0, wo, sidx, m_sector[sidx], 0, 1));
      end
      lbbc_pkg::ActSync: begin
        if (dirty_q.size() == 0) begin
          result_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1));
          return;
        end
        k = 0;
        while (dirty_q.size() > 0 && k < lbbc_pkg::MaxRes) begin
          s = dirty_q.pop_front();
          m_dirty[s] = 0;
          k++;
          result_q.push_back(mk(s, 0, 0, 1, s, m_sector[s], 0,
                                dirty_q.size() == 0 || k == lbbc_pkg::MaxRes));
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) if (m_valid[i]) begin
          drop_from(lru_q, i[3:0]);
          free_q.push_front(i[3:0]);
          m_valid[i] = 0; m_dirty[i] = 0; m_sector[i] = 0;
        end
        dirty_q.delete();
        result_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endtask

  // one request transfer, with its prediction queued at the accepting edge
  task automatic send_request(input logic [1:0] act, input logic [31:0] blk,
                              input logic [3:0] sidx, input logic [1:0] mode);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.block_number <= blk;
    req_if.slot_index <= sidx;
    req_if.put_mode <= mode;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(act, blk, sidx, mode);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == lbbc_pkg::CfgWtImm) wt_imm = val;
    else if (idx == lbbc_pkg::CfgWtEvery) wt_every = val;
    @(posedge clk_i);
  endtask

  // drain results, then allow for an invalidate still stepping
  task automatic settle();
    req_if.valid <= 1'b0;
    while (result_q.size() > 0) @(posedge clk_i);
    repeat (NSLOT + 40) @(posedge clk_i);
  endtask

  // result sink with random backpressure bursts
  initial begin
    int hold;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && hold == 0 && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 13);
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else res_if.ready <= 1'b1;
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    lbbc_pkg::out_item_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.slot = res_if.slot; got.hit = res_if.hit; got.fill_read = res_if.fill_read;
      got.write_out = res_if.write_out; got.write_slot = res_if.write_slot;
      got.write_sector = res_if.write_sector; got.status = res_if.status;
      got.last = res_if.last;
      if (result_q.size() == 0) report("result transfer with nothing expected");
      else begin
        want = result_q.pop_front();
        if (got.slot !== want.slot) report($sformatf("slot %0d want %0d", got.slot, want.slot));
        if (got.hit !== want.hit) report("hit");
        if (got.fill_read !== want.fill_read) report("fill_read");
        if (got.write_out !== want.write_out) report("write_out");
        if (got.write_slot !== want.write_slot) report("write_slot");
        if (got.write_sector !== want.write_sector)
          report($sformatf("write_sector %h want %h", got.write_sector, want.write_sector));
        if (got.status !== want.status) report("status");
        if (got.last !== want.last) report("last");
      end
    end
  end

  // directed rows: act, block, slot, mode, typed check, typed result
  typedef struct {
    logic [1:0] act; logic [31:0] blk; logic [3:0] sidx; logic [1:0] mode;
    bit chk; lbbc_pkg::out_item_t exp;
  } row_t;
  row_t dir_tab [] = '{
    '{lbbc_pkg::ActSync, 0, 0, 0, 1'b1, ExpLast},          // nothing dirty
    '{lbbc_pkg::ActPut, 0, 15, 0, 1'b1, ExpBadSlot15},     // put to a slot not in use
    '{lbbc_pkg::ActGet, 32'h0, 0, 0, 1'b1, ExpFill0},
    '{lbbc_pkg::ActGet, 32'hFFFFFFFF, 0, 0, 1'b1, ExpFill1},
    '{lbbc_pkg::ActGet, 32'h0, 0, 0, 1'b1, ExpHit0},       // hit
    '{lbbc_pkg::ActPut, 0, 1, 0, 1'b0, '0},                // lazy put
    '{lbbc_pkg::ActPut, 0, 0, 1, 1'b0, '0},                // immediate put
    '{lbbc_pkg::ActPut, 0, 1, 2, 1'b0, '0},                // oneshot
    '{lbbc_pkg::ActPut, 0, 0, 3, 1'b0, '0},
    '{lbbc_pkg::ActSync, 0, 0, 0, 1'b0, '0},
    '{lbbc_pkg::ActInval, 0, 0, 0, 1'b1, ExpLast},
    '{lbbc_pkg::ActPut, 0, 0, 0, 1'b1, ExpBadSlot0},       // freed slot
    '{lbbc_pkg::ActGet, 32'h5A5A5A5A, 0, 0, 1'b0, '0}
  };

  initial begin
    logic [31:0] pool [8];
    int r;
    req_if.valid = 0; req_if.action = 0; req_if.block_number = 0;
    req_if.slot_index = 0; req_if.put_mode = 0;
    cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
    wt_imm = 0; wt_every = 0;
    for (int i = 0; i < NSLOT; i++) begin
      m_sector[i] = 0; m_valid[i] = 0; m_dirty[i] = 0;
      free_q.push_back(i[3:0]);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].act, dir_tab[i].blk, dir_tab[i].sidx, dir_tab[i].mode);
      if (dir_tab[i].chk) begin
        void'(result_q.pop_back());
        result_q.push_back(dir_tab[i].exp);
      end
    end
    // fill all slots dirty, then evict a dirty victim and flush the rest with a sync
    for (int i = 0; i < NSLOT; i++) send_request(lbbc_pkg::ActGet, 32'h100 + i, 0, 0);
    for (int i = 0; i < NSLOT; i++) send_request(lbbc_pkg::ActPut, 0, i[3:0], 0);
    send_request(lbbc_pkg::ActGet, 32'hDEAD0000, 0, 0);
    send_request(lbbc_pkg::ActSync, 0, 0, 0);

    // random phases through all register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(lbbc_pkg::CfgWtImm, ph[0]);
      write_reg(lbbc_pkg::CfgWtEvery, ph[1]);
      if (ph == 4) begin
        write_reg(8'hFF, 1'b1);    // unknown index, ignored
        quiet = 1'b1;
      end
      foreach (pool[i]) pool[i] = (ph == 2) ? $urandom : 32'hFFFF_FFF0 + $urandom_range(0, 31);
      for (int n = 0; n < 52; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45) send_request(lbbc_pkg::ActGet, ($urandom_range(0, 9) == 0) ? $urandom
                                 : pool[$urandom_range(0, 7)] ^ $urandom_range(0, 20),
                                 4'($urandom), 2'($urandom));
        else if (r < 85) send_request(lbbc_pkg::ActPut, $urandom, 4'($urandom), 2'($urandom));
        else if (r < 96) send_request(lbbc_pkg::ActSync, $urandom, 4'($urandom),
                                      2'($urandom));
        else send_request(lbbc_pkg::ActInval, $urandom, 4'($urandom), 2'($urandom));
      end
    end
    settle();
    if (n_errors == 0 && result_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- lru_block_buffer_cache_tags_top.f -----
+incdir+sv
sv/lbbc_pkg.sv
sv/lbbc_if.sv
sv/lbbc_cell.sv
sv/lru_block_buffer_cache_tags_top.sv
tb/tb_lru_block_buffer_cache_tags_top.sv
